### rtl/core/glr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glr_pkg;

   // Field widths of the request and response payloads.
   localparam int X_W     = 9;
   localparam int Y_W     = 8;
   localparam int COLOR_W = 8;
   localparam int ADDR_W  = 16;

   // Default frame buffer geometry.
   localparam int SCREEN_WIDTH_DEFAULT = 320;

   // Request mode codes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

endpackage

`default_nettype wire

### rtl/core/glr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: line loads and pixel step requests.
interface glr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [glr_pkg::X_W-1:0]        x_start;
   logic [glr_pkg::Y_W-1:0]        y_start;
   logic [glr_pkg::X_W-1:0]        x_end;
   logic [glr_pkg::Y_W-1:0]        y_end;
   logic [glr_pkg::COLOR_W-1:0]    start_color;
   logic [glr_pkg::COLOR_W-1:0]    end_color;

   modport source (
      output valid, mode, x_start, y_start, x_end, y_end, start_color, end_color,
      input  ready
   );

   modport sink (
      input  valid, mode, x_start, y_start, x_end, y_end, start_color, end_color,
      output ready
   );
endinterface

// Response channel: one emitted pixel per transfer.
interface glr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [glr_pkg::X_W-1:0]        pixel_x;
   logic [glr_pkg::Y_W-1:0]        pixel_y;
   logic [glr_pkg::ADDR_W-1:0]     pixel_address;
   logic [glr_pkg::COLOR_W-1:0]    pixel_color;
   logic                           last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
      output ready
   );
endinterface

`default_nettype wire

### rtl/core/gradient_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake      Moves
// req_ch    in         valid/ready    load of a line (mode 0) or pixel step (mode 1)
// rsp_ch    out        valid/ready    one pixel: column, row, address, color, last flag
//
// A step transfer puts its pixel in the response register on the next cycle.
// A load latches its line, then runs eight restoring division iterations of the shared
// subtractor and a sign correction step; the request side is not ready meanwhile.
// Reset clears the sequencer, the active line flag and the response valid.
// A stalled response holds its pixel; a new request is taken only when the response
// register is empty or being drained in the same cycle.

module gradient_line_rasterizer #(
   parameter int SCREEN_WIDTH = glr_pkg::SCREEN_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   glr_req_if.sink    req_ch,
   glr_rsp_if.source  rsp_ch
);

   // Sequencer codes.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FIXUP  = 2'd2;

   // Control registers.
   logic [1:0]         state_ff, state_in;
   logic               line_active_ff, line_active_in;
   logic               out_valid_ff, out_valid_in;

   // Line walk registers.
   logic [8:0]         cur_col_ff, cur_col_in;
   logic [7:0]         cur_row_ff, cur_row_in;
   logic signed [11:0] decision_ff, decision_in;
   logic signed [11:0] straight_ff, straight_in;
   logic signed [11:0] diagonal_ff, diagonal_in;
   logic               major_x_ff, major_x_in;
   logic               x_neg_ff, x_neg_in;
   logic               y_neg_ff, y_neg_in;
   logic [9:0]         pixels_left_ff, pixels_left_in;

   // Color ramp registers.
   logic [7:0]         ramp_base_ff, ramp_base_in;
   logic signed [8:0]  ramp_quotient_ff, ramp_quotient_in;
   logic [9:0]         ramp_remainder_ff, ramp_remainder_in;
   logic [9:0]         ramp_divisor_ff, ramp_divisor_in;
   logic signed [8:0]  ramp_whole_ff, ramp_whole_in;
   logic [9:0]         ramp_fraction_ff, ramp_fraction_in;

   // Divider working registers.
   logic [7:0]         div_num_ff, div_num_in;
   logic               div_neg_ff, div_neg_in;
   logic [7:0]         div_quo_ff, div_quo_in;
   logic [2:0]         div_count_ff, div_count_in;

   // Response registers.
   logic [glr_pkg::X_W-1:0]     out_x_ff, out_x_in;
   logic [glr_pkg::Y_W-1:0]     out_y_ff, out_y_in;
   logic [glr_pkg::ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [glr_pkg::COLOR_W-1:0] out_color_ff, out_color_in;
   logic                        out_last_ff, out_last_in;

   // Handshake.
   logic req_ready;
   logic req_fire;
   logic load_fire;
   logic step_fire;

   assign req_ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_ch.ready);
   assign req_fire  = req_ch.valid && req_ready;
   assign load_fire = req_fire && (req_ch.mode == glr_pkg::MODE_LOAD);
   assign step_fire = req_fire && (req_ch.mode == glr_pkg::MODE_STEP) && line_active_ff;

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.pixel_x       = out_x_ff;
   assign rsp_ch.pixel_y       = out_y_ff;
   assign rsp_ch.pixel_address = out_addr_ff;
   assign rsp_ch.pixel_color   = out_color_ff;
   assign rsp_ch.last_pixel    = out_last_ff;

   // Line setup from the endpoints and colors of a load.
   logic [8:0]  dx;
   logic [8:0]  dy;
   logic [8:0]  major;
   logic [8:0]  minor;
   logic        color_neg;
   logic [7:0]  color_mag;

   always_comb begin
      dx = (req_ch.x_start > req_ch.x_end) ? (req_ch.x_start - req_ch.x_end)
                                           : (req_ch.x_end - req_ch.x_start);
      dy = (req_ch.y_start > req_ch.y_end) ? {1'b0, req_ch.y_start - req_ch.y_end}
                                           : {1'b0, req_ch.y_end - req_ch.y_start};
      major     = (dx >= dy) ? dx : dy;
      minor     = (dx >= dy) ? dy : dx;
      color_neg = req_ch.end_color < req_ch.start_color;
      color_mag = color_neg ? (req_ch.start_color - req_ch.end_color)
                            : (req_ch.end_color - req_ch.start_color);
   end

   // Shared subtractor: division trial step, then the remainder correction.
   logic [10:0] sub_a;
   logic [10:0] sub_b;
   logic [11:0] sub_res;
   logic        sub_borrow;

   always_comb begin
      unique case (state_ff)
         ST_DIVIDE: begin
            sub_a = {ramp_remainder_ff, div_num_ff[7]};
            sub_b = {1'b0, ramp_divisor_ff};
         end
         default: begin
            sub_a = {1'b0, ramp_divisor_ff};
            sub_b = {1'b0, ramp_remainder_ff};
         end
      endcase
      sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
      sub_borrow = sub_res[11];
   end

   // Pixel step: Bresenham move, ramp accumulation and address.
   logic [10:0] frac_sum;
   logic        frac_wrap;
   logic        is_last;
   logic [31:0] addr_full;

   always_comb begin
      frac_sum  = {1'b0, ramp_fraction_ff} + {1'b0, ramp_remainder_ff};
      frac_wrap = frac_sum >= {1'b0, ramp_divisor_ff};
      is_last   = pixels_left_ff <= 10'd1;
      addr_full = 32'(cur_col_ff) + 32'(cur_row_ff) * 32'(SCREEN_WIDTH);
   end

   // Next-state logic.
   always_comb begin
      state_in          = state_ff;
      line_active_in    = line_active_ff;
      cur_col_in        = cur_col_ff;
      cur_row_in        = cur_row_ff;
      decision_in       = decision_ff;
      straight_in       = straight_ff;
      diagonal_in       = diagonal_ff;
      major_x_in        = major_x_ff;
      x_neg_in          = x_neg_ff;
      y_neg_in          = y_neg_ff;
      pixels_left_in    = pixels_left_ff;
      ramp_base_in      = ramp_base_ff;
      ramp_quotient_in  = ramp_quotient_ff;
      ramp_remainder_in = ramp_remainder_ff;
      ramp_divisor_in   = ramp_divisor_ff;
      ramp_whole_in     = ramp_whole_ff;
      ramp_fraction_in  = ramp_fraction_ff;
      div_num_in        = div_num_ff;
      div_neg_in        = div_neg_ff;
      div_quo_in        = div_quo_ff;
      div_count_in      = div_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load_fire) begin
               // Latch the line and start the color division.
               line_active_in    = 1'b0;
               cur_col_in        = req_ch.x_start;
               cur_row_in        = req_ch.y_start;
               major_x_in        = dx >= dy;
               x_neg_in          = req_ch.x_start > req_ch.x_end;
               y_neg_in          = req_ch.y_start > req_ch.y_end;
               straight_in       = $signed({2'b00, minor, 1'b0});
               diagonal_in       = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
               decision_in       = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
               pixels_left_in    = {1'b0, major} + 10'd1;
               ramp_base_in      = req_ch.start_color;
               ramp_divisor_in   = {1'b0, major} + 10'd2;
               ramp_remainder_in = '0;
               div_num_in        = color_mag;
               div_neg_in        = color_neg;
               div_quo_in        = '0;
               div_count_in      = 3'd7;
               state_in          = ST_DIVIDE;
            end else if (step_fire) begin
               if (decision_ff[11]) begin
                  decision_in = decision_ff + straight_ff;
                  if (major_x_ff) begin
                     cur_col_in = x_neg_ff ? cur_col_ff - 9'd1 : cur_col_ff + 9'd1;
                  end else begin
                     cur_row_in = y_neg_ff ? cur_row_ff - 8'd1 : cur_row_ff + 8'd1;
                  end
               end else begin
                  decision_in = decision_ff + diagonal_ff;
                  cur_col_in  = x_neg_ff ? cur_col_ff - 9'd1 : cur_col_ff + 9'd1;
                  cur_row_in  = y_neg_ff ? cur_row_ff - 8'd1 : cur_row_ff + 8'd1;
               end
               ramp_whole_in = ramp_whole_ff + ramp_quotient_ff + $signed({8'd0, frac_wrap});
               ramp_fraction_in = frac_wrap ? 10'(frac_sum - {1'b0, ramp_divisor_ff})
                                            : frac_sum[9:0];
               if (is_last) begin
                  pixels_left_in = '0;
                  line_active_in = 1'b0;
               end else begin
                  pixels_left_in = pixels_left_ff - 10'd1;
               end
            end
         end
         ST_DIVIDE: begin
            // One restoring division step per cycle on the color magnitude.
            if (!sub_borrow) begin
               ramp_remainder_in = sub_res[9:0];
            end else begin
               ramp_remainder_in = sub_a[9:0];
            end
            div_quo_in   = {div_quo_ff[6:0], !sub_borrow};
            div_num_in   = {div_num_ff[6:0], 1'b0};
            div_count_in = div_count_ff - 3'd1;
            if (div_count_ff == 3'd0) begin
               state_in = ST_FIXUP;
            end
         end
         ST_FIXUP: begin
            // Turn the magnitude result into a floor quotient and a non-negative remainder.
            if (div_neg_ff && (ramp_remainder_ff != '0)) begin
               ramp_quotient_in  = ~$signed({1'b0, div_quo_ff});
               ramp_remainder_in = sub_res[9:0];
            end else if (div_neg_ff) begin
               ramp_quotient_in  = -$signed({1'b0, div_quo_ff});
            end else begin
               ramp_quotient_in  = $signed({1'b0, div_quo_ff});
            end
            ramp_whole_in    = ramp_quotient_in;
            ramp_fraction_in = ramp_remainder_in;
            line_active_in   = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_x_in     = cur_col_ff;
         out_y_in     = cur_row_ff;
         out_addr_in  = addr_full[glr_pkg::ADDR_W-1:0];
         out_color_in = ramp_base_ff + ramp_whole_ff[7:0];
         out_last_in  = is_last;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Working and payload state.
   always_ff @(posedge clock) begin
      cur_col_ff        <= cur_col_in;
      cur_row_ff        <= cur_row_in;
      decision_ff       <= decision_in;
      straight_ff       <= straight_in;
      diagonal_ff       <= diagonal_in;
      major_x_ff        <= major_x_in;
      x_neg_ff          <= x_neg_in;
      y_neg_ff          <= y_neg_in;
      pixels_left_ff    <= pixels_left_in;
      ramp_base_ff      <= ramp_base_in;
      ramp_quotient_ff  <= ramp_quotient_in;
      ramp_remainder_ff <= ramp_remainder_in;
      ramp_divisor_ff   <= ramp_divisor_in;
      ramp_whole_ff     <= ramp_whole_in;
      ramp_fraction_ff  <= ramp_fraction_in;
      div_num_ff        <= div_num_in;
      div_neg_ff        <= div_neg_in;
      div_quo_ff        <= div_quo_in;
      div_count_ff      <= div_count_in;
      out_x_ff          <= out_x_in;
      out_y_ff          <= out_y_in;
      out_addr_ff       <= out_addr_in;
      out_color_ff      <= out_color_in;
      out_last_ff       <= out_last_in;
   end

endmodule

`default_nettype wire

### rtl/core/glr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module glr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [glr_pkg::X_W-1:0]       rsp_pixel_x,
   input wire logic [glr_pkg::Y_W-1:0]       rsp_pixel_y,
   input wire logic [glr_pkg::ADDR_W-1:0]    rsp_pixel_address,
   input wire logic [glr_pkg::COLOR_W-1:0]   rsp_pixel_color,
   input wire logic                          rsp_last_pixel
);

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // A stalled response keeps its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_pixel_address) && $stable(rsp_pixel_color)
         && $stable(rsp_last_pixel))
      else $error("stalled response payload changed");

   // A load keeps the request side busy while the ramp division runs.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == glr_pkg::MODE_LOAD) |=> !req_ready)
      else $error("request accepted during line setup");

   // A new pixel appears only after a step transfer.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_mode == glr_pkg::MODE_STEP)))
      else $error("pixel emitted without a step transfer");

endmodule

bind gradient_line_rasterizer glr_checker u_glr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_mode          (req_ch.mode),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_pixel_x       (rsp_ch.pixel_x),
   .rsp_pixel_y       (rsp_ch.pixel_y),
   .rsp_pixel_address (rsp_ch.pixel_address),
   .rsp_pixel_color   (rsp_ch.pixel_color),
   .rsp_last_pixel    (rsp_ch.last_pixel)
);

`default_nettype wire

### dv/gradient_line_rasterizer_tb.sv
`timescale 1ns / 1ps

module gradient_line_rasterizer_tb;

   localparam int CLOCK_PERIOD = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int REPORT_LIMIT = 10;

   // One request as it crosses the request channel.
   typedef struct packed {
      logic                        mode;
      logic [glr_pkg::X_W-1:0]     x_start;
      logic [glr_pkg::Y_W-1:0]     y_start;
      logic [glr_pkg::X_W-1:0]     x_end;
      logic [glr_pkg::Y_W-1:0]     y_end;
      logic [glr_pkg::COLOR_W-1:0] start_color;
      logic [glr_pkg::COLOR_W-1:0] end_color;
   } line_req_t;

   // One emitted pixel as it crosses the response channel.
   typedef struct packed {
      logic [glr_pkg::X_W-1:0]     pixel_x;
      logic [glr_pkg::Y_W-1:0]     pixel_y;
      logic [glr_pkg::ADDR_W-1:0]  pixel_address;
      logic [glr_pkg::COLOR_W-1:0] pixel_color;
      logic                        last_pixel;
   } pixel_t;

   // Walks the line exactly as the engine should and holds the pixels still to come.
   class pixel_scoreboard;
      pixel_t      expected_pixels[$];
      bit          active;
      logic [9:0]  col;
      logic [9:0]  row;
      int          decision;
      int          straight_inc;
      int          diag_inc;
      bit          major_x;
      bit          x_neg;
      bit          y_neg;
      int          pixels_left;
      int          ramp_base;
      int          ramp_quot;
      int          ramp_rem;
      int          ramp_div;
      int          ramp_whole;
      int          ramp_frac;
      int unsigned mismatch_count;
      int unsigned loads_seen;
      int unsigned pixels_checked;
      int unsigned idle_steps;

      function new();
         active = 0;
      endfunction

      function void note_request(line_req_t r);
         int     x1, y1, x2, y2, dx, dy, major, minor, diff, q, rem;
         pixel_t p;
         if (r.mode == glr_pkg::MODE_LOAD) begin
            // Line setup: major axis, Bresenham terms and the exact color split.
            x1 = int'(r.x_start);
            y1 = int'(r.y_start);
            x2 = int'(r.x_end);
            y2 = int'(r.y_end);
            dx = (x1 > x2) ? x1 - x2 : x2 - x1;
            dy = (y1 > y2) ? y1 - y2 : y2 - y1;
            major_x = (dx >= dy);
            major = major_x ? dx : dy;
            minor = major_x ? dy : dx;
            x_neg = (x1 > x2);
            y_neg = (y1 > y2);
            decision = 2 * minor - major;
            straight_inc = 2 * minor;
            diag_inc = 2 * (minor - major);
            pixels_left = major + 1;
            col = 10'(x1);
            row = 10'(y1);
            ramp_base = int'(r.start_color);
            ramp_div = major + 2;
            diff = int'(r.end_color) - int'(r.start_color);
            q = diff / ramp_div;
            rem = diff % ramp_div;
            if (rem < 0) begin
               rem += ramp_div;
               q -= 1;
            end
            ramp_quot = q;
            ramp_rem = rem;
            ramp_whole = q;
            ramp_frac = rem;
            active = 1;
            loads_seen++;
         end else if (!active) begin
            idle_steps++;
         end else begin
            // Emit the current pixel, then advance position and color ramp.
            p.pixel_x = col[glr_pkg::X_W-1:0];
            p.pixel_y = row[glr_pkg::Y_W-1:0];
            p.pixel_address = 16'(int'(col) + int'(row) * glr_pkg::SCREEN_WIDTH_DEFAULT);
            p.pixel_color = 8'(ramp_base + ramp_whole);
            p.last_pixel = (pixels_left <= 1);
            expected_pixels.push_back(p);
            if (decision < 0) begin
               decision += straight_inc;
               if (major_x) begin
                  col = x_neg ? col - 10'd1 : col + 10'd1;
               end else begin
                  row = y_neg ? row - 10'd1 : row + 10'd1;
               end
            end else begin
               decision += diag_inc;
               col = x_neg ? col - 10'd1 : col + 10'd1;
               row = y_neg ? row - 10'd1 : row + 10'd1;
            end
            ramp_whole += ramp_quot;
            ramp_frac += ramp_rem;
            if (ramp_frac >= ramp_div) begin
               ramp_frac -= ramp_div;
               ramp_whole += 1;
            end
            if (p.last_pixel) begin
               pixels_left = 0;
               active = 0;
            end else begin
               pixels_left -= 1;
            end
         end
      endfunction

      function void check_pixel(pixel_t got);
         pixel_t want;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: pixel transfer with none expected: x=%0d y=%0d addr=%0d color=%0d last=%0b",
                        $realtime, got.pixel_x, got.pixel_y, got.pixel_address,
                        got.pixel_color, got.last_pixel);
            return;
         end
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.pixel_address !== want.pixel_address ||
             got.pixel_color !== want.pixel_color ||
             got.last_pixel !== want.last_pixel) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: pixel mismatch", $realtime);
               $display("   expected x=%0d y=%0d addr=%0d color=%0d last=%0b",
                        want.pixel_x, want.pixel_y, want.pixel_address,
                        want.pixel_color, want.last_pixel);
               $display("   actual   x=%0d y=%0d addr=%0d color=%0d last=%0b",
                        got.pixel_x, got.pixel_y, got.pixel_address,
                        got.pixel_color, got.last_pixel);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   sender_idle_pct = 9;
   int   receiver_stall_pct = 73;
   int unsigned cycle_count = 0;

   pixel_scoreboard sb = new();

   glr_req_if req_ch ();
   glr_rsp_if rsp_ch ();

   gradient_line_rasterizer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Drive every block input to a known value from time zero.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = glr_pkg::MODE_LOAD;
      req_ch.x_start = '0;
      req_ch.y_start = '0;
      req_ch.x_end = '0;
      req_ch.y_end = '0;
      req_ch.start_color = '0;
      req_ch.end_color = '0;
      rsp_ch.ready = 1'b0;
   end

   // Receiver back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watch both channels; a response is always older than a request in the same cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_pixel({rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.pixel_address,
                            rsp_ch.pixel_color, rsp_ch.last_pixel});
         if (req_ch.valid && req_ch.ready)
            sb.note_request({req_ch.mode, req_ch.x_start, req_ch.y_start, req_ch.x_end,
                             req_ch.y_end, req_ch.start_color, req_ch.end_color});
      end
   end

   // Run time guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic line_req_t make_load(int x1, int y1, int x2, int y2, int sc, int ec);
      line_req_t r;
      r.mode = glr_pkg::MODE_LOAD;
      r.x_start = 9'(x1);
      r.y_start = 8'(y1);
      r.x_end = 9'(x2);
      r.y_end = 8'(y2);
      r.start_color = 8'(sc);
      r.end_color = 8'(ec);
      return r;
   endfunction

   // Step requests carry random junk in the fields that a step ignores.
   function automatic line_req_t make_step();
      line_req_t r;
      r.mode = glr_pkg::MODE_STEP;
      r.x_start = 9'($urandom);
      r.y_start = 8'($urandom);
      r.x_end = 9'($urandom);
      r.y_end = 8'($urandom);
      r.start_color = 8'($urandom);
      r.end_color = 8'($urandom);
      return r;
   endfunction

   // Present one request from a falling edge and hold it until its transfer.
   task automatic send_request(line_req_t r);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= r.mode;
      req_ch.x_start <= r.x_start;
      req_ch.y_start <= r.y_start;
      req_ch.x_end <= r.x_end;
      req_ch.y_end <= r.y_end;
      req_ch.start_color <= r.start_color;
      req_ch.end_color <= r.end_color;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_steps(int count);
      for (int k = 0; k < count; k++) send_request(make_step());
   endtask

   // Pick an end coordinate a given distance away that stays inside the field.
   function automatic int offset_coord(int base, int delta, int max_val);
      if ((($urandom & 1) && base + delta <= max_val) || base < delta)
         return base + delta;
      return base - delta;
   endfunction

   // Mostly short lines walked to the end, some cut short or overrun by extra steps.
   task automatic run_random_lines(int item_goal);
      int items;
      int x1, y1, x2, y2, sc, ec, lim, npix, nsteps, pick;
      items = 0;
      while (items < item_goal) begin
         pick = $urandom_range(99);
         x1 = $urandom_range(511);
         y1 = $urandom_range(255);
         if (pick < 3) begin
            x2 = $urandom_range(511);
            y2 = $urandom_range(255);
         end else begin
            lim = (pick < 20) ? 40 : 12;
            x2 = offset_coord(x1, $urandom_range(lim), 511);
            y2 = offset_coord(y1, $urandom_range(lim), 255);
         end
         pick = $urandom_range(99);
         sc = $urandom_range(255);
         ec = $urandom_range(255);
         if (pick < 10) begin
            ec = sc;
         end else if (pick < 20) begin
            sc = ($urandom & 1) ? 255 : 0;
            ec = 255 - sc;
         end
         send_request(make_load(x1, y1, x2, y2, sc, ec));
         items++;
         npix = ((x1 > x2) ? x1 - x2 : x2 - x1);
         if (((y1 > y2) ? y1 - y2 : y2 - y1) > npix)
            npix = (y1 > y2) ? y1 - y2 : y2 - y1;
         npix += 1;
         pick = $urandom_range(99);
         if (pick < 75) nsteps = npix;
         else if (pick < 88) nsteps = $urandom_range(npix - 1);
         else nsteps = npix + $urandom_range(1, 3);
         // Keep the item count near the goal even when a long line comes last.
         if (nsteps > item_goal - items) nsteps = item_goal - items;
         send_steps(nsteps);
         items += nsteps;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: idle step, degenerate and extreme lines, x-major and y-major octants.
      send_request(make_step());
      send_request(make_load(0, 0, 0, 0, 0, 255));
      send_steps(2);
      send_request(make_load(319, 199, 316, 199, 255, 0));
      send_steps(4);
      send_request(make_load(0, 0, 2, 5, 10, 10));
      send_steps(3);
      send_request(make_load(511, 255, 508, 253, 0, 255));
      send_steps(4);
      send_request(make_load(511, 255, 511, 255, 255, 255));
      send_steps(1);
      send_request(make_load(0, 255, 511, 0, 200, 17));
      send_steps(2);

      // Random part under three pacing settings.
      run_random_lines(345);
      sender_idle_pct = 73;
      receiver_stall_pct = 9;
      run_random_lines(345);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      run_random_lines(345);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.expected_pixels.size() != 0) begin
         sb.mismatch_count += sb.expected_pixels.size();
         $display("%0d expected pixels never arrived", sb.expected_pixels.size());
      end
      $display("Run covered %0d line loads and %0d checked pixels; %0d steps found no line.",
               sb.loads_seen, sb.pixels_checked, sb.idle_steps);
      $display("Pacing went from a stalling receiver to an idling sender to full rate.");
      if (sb.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d failures", sb.mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/glr_pkg.sv
rtl/core/glr_req_if.sv
rtl/core/gradient_line_rasterizer.sv
rtl/core/glr_checker.sv
dv/gradient_line_rasterizer_tb.sv
